>>> rtl/core/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the calibrator top level
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/isoc_pkg.sv
// -----------------------------------------------------------------------------
// isoc_pkg
// Types and constants of the still-offset calibrator
// -----------------------------------------------------------------------------
package isoc_pkg;

	localparam int NUM_AXES   = 6;
	localparam int NUM_ACCEL  = 3;
	localparam int ACCEL_BASE = 3;
	localparam int AX_ACCEL_Z = 5;

	// configuration register indexes
	localparam logic [1:0] CFG_STILL_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_STILL_SAMPLES   = 2'd1;
	localparam logic [1:0] CFG_GRAVITY_REF     = 2'd2;

	localparam logic [15:0] RST_STILL_THRESHOLD = 16'd400;
	localparam logic [7:0]  RST_STILL_SAMPLES   = 8'd100;
	localparam logic [14:0] RST_GRAVITY_REF     = 15'd16384;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_START  = 1'b1;

	typedef enum logic [1:0] {
		PH_RUN  = 2'd0,
		PH_WAIT = 2'd1,
		PH_AVG  = 2'd2
	} phase_t;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] raw_gyro_x;
		logic signed [15:0] raw_gyro_y;
		logic signed [15:0] raw_gyro_z;
		logic signed [15:0] raw_accel_x;
		logic signed [15:0] raw_accel_y;
		logic signed [15:0] raw_accel_z;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] cor_gyro_x;
		logic signed [15:0] cor_gyro_y;
		logic signed [15:0] cor_gyro_z;
		logic signed [15:0] cor_accel_x;
		logic signed [15:0] cor_accel_y;
		logic signed [15:0] cor_accel_z;
		logic [1:0]         phase;
		logic               offsets_updated;
	} result_t;

	// controls from the sequencer to every axis lane
	typedef struct packed {
		logic clr;     // clear offset and sum
		logic add;     // accumulate this request
		logic div_ld;  // load offset from the divide stage
	} lane_ctl_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic   busy;
		logic   fin;
		phase_t phase;
		logic   updated;
	} ctrl_st_t;

endpackage

>>> rtl/core/isoc_still.sv
// -----------------------------------------------------------------------------
// isoc_still
// Stillness check of one accel axis against the previous corrected sample
// -----------------------------------------------------------------------------
module isoc_still
	import isoc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] cor,
	input  logic [15:0]        thr,
	input  logic               ld,
	output logic               still
);

	logic signed [15:0] prev_q;
	logic signed [16:0] diff;
	logic [16:0]        mag;

	assign diff  = {cor[15], cor} - {prev_q[15], prev_q};
	assign mag   = diff[16] ? 17'(-diff) : 17'(diff);
	assign still = mag < {1'b0, thr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (ld) begin
			prev_q <= cor;
		end
	end

endmodule

>>> rtl/core/isoc_lane.sv
// -----------------------------------------------------------------------------
// isoc_lane
// One axis: offset subtract, calibration sum and divide by the sample count
// -----------------------------------------------------------------------------
module isoc_lane
	import isoc_pkg::*;
#(
	parameter int AVG_SAMPLES = 100
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] raw,
	input  logic [14:0]        grav,
	input  lane_ctl_t          ctl,
	output logic signed [15:0] cor
);

	// exact truncating divide of a 24-bit magnitude by a reciprocal multiply
	localparam int DivShift = 24 + $clog2(AVG_SAMPLES);
	localparam int RecipW   = 26;
	localparam int ProdW    = 24 + RecipW;
	localparam logic [63:0] RecipFull =
		((64'd1 << DivShift) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES);
	localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];

	logic signed [15:0] off_q;
	logic [23:0]        sum_q;
	logic [23:0]        sum_d;
	logic [23:0]        mag;
	logic [ProdW-1:0]   prod_s2;
	logic               neg_s2;
	logic [15:0]        q16;

	assign cor   = raw - off_q;
	assign sum_d = sum_q + {{8{cor[15]}}, cor} - {9'd0, grav};
	assign mag   = sum_q[23] ? (~sum_q + 24'd1) : sum_q;
	assign q16   = prod_s2[DivShift +: 16];

	always_ff @(posedge clk) begin
		prod_s2 <= ProdW'(mag) * ProdW'(Recip);
		neg_s2  <= sum_q[23];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			sum_q <= '0;
		end else begin
			if (ctl.clr) begin
				off_q <= '0;
				sum_q <= '0;
			end else begin
				if (ctl.add) begin
					sum_q <= sum_d;
				end
				// only the low 16 bits of the quotient reach the wrapped result
				if (ctl.div_ld) begin
					off_q <= neg_s2 ? (~q16 + 16'd1) : q16;
				end
			end
		end
	end

endmodule

>>> rtl/core/isoc_ctrl.sv
// -----------------------------------------------------------------------------
// isoc_ctrl
// Calibration sequencer: merges the lane stillness flags and counts samples
// -----------------------------------------------------------------------------
module isoc_ctrl
	import isoc_pkg::*;
#(
	parameter int AVG_SAMPLES = 100
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic                 cmd,
	input  logic [NUM_ACCEL-1:0] still,
	input  logic [7:0]           still_samples,
	output logic                 prev_ld,
	output lane_ctl_t            lane_ctl,
	output ctrl_st_t             st
);

	localparam int CntW = $clog2(AVG_SAMPLES + 1);

	phase_t          ph_q;
	phase_t          ph_d;
	logic            have_prev_q;
	logic [7:0]      still_cnt_q;
	logic [7:0]      still_next;
	logic [CntW-1:0] avg_cnt_q;
	logic [CntW-1:0] avg_next;
	logic            all_still;
	logic            wait_done;
	logic            avg_done;
	logic            fin;
	logic            div_s1;
	logic            div_s2;

	assign all_still  = &still;
	assign still_next = all_still ? (still_cnt_q + 8'd1) : 8'd0;
	assign wait_done  = have_prev_q && (still_next >= still_samples);
	assign avg_next   = avg_cnt_q + CntW'(1);
	assign avg_done   = avg_next >= CntW'(AVG_SAMPLES);

	// next state
	always_comb begin
		ph_d = ph_q;
		if (acc) begin
			case (ph_q)
				PH_RUN: begin
					if (cmd == CMD_START) ph_d = PH_WAIT;
				end
				PH_WAIT: begin
					if (wait_done) ph_d = PH_AVG;
				end
				PH_AVG: begin
					if (avg_done) ph_d = PH_RUN;
				end
				default: begin
					ph_d = PH_RUN;
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		prev_ld      = 1'b0;
		lane_ctl.clr = 1'b0;
		lane_ctl.add = 1'b0;
		fin          = 1'b0;
		case (ph_q)
			PH_RUN: begin
				prev_ld = acc && (cmd == CMD_START);
			end
			PH_WAIT: begin
				prev_ld      = acc;
				lane_ctl.clr = acc && wait_done;
			end
			PH_AVG: begin
				lane_ctl.add = acc;
				fin          = acc && avg_done;
			end
			default: begin
				prev_ld = 1'b0;
			end
		endcase
		lane_ctl.div_ld = div_s2;
	end

	assign st.busy    = div_s1 | div_s2;
	assign st.fin     = fin;
	assign st.phase   = ph_d;
	assign st.updated = fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_RUN;
			have_prev_q <= 1'b0;
			still_cnt_q <= '0;
			avg_cnt_q   <= '0;
			div_s1      <= 1'b0;
			div_s2      <= 1'b0;
		end else begin
			ph_q   <= ph_d;
			div_s1 <= fin;
			div_s2 <= div_s1;
			if (acc) begin
				case (ph_q)
					PH_RUN: begin
						if (cmd == CMD_START) begin
							have_prev_q <= 1'b1;
							still_cnt_q <= '0;
						end
					end
					PH_WAIT: begin
						// first request without a reference only takes it
						if (!have_prev_q) begin
							have_prev_q <= 1'b1;
							still_cnt_q <= '0;
						end else begin
							still_cnt_q <= still_next;
							if (wait_done) begin
								have_prev_q <= 1'b0;
								avg_cnt_q   <= '0;
							end
						end
					end
					PH_AVG: begin
						if (avg_done) begin
							avg_cnt_q   <= '0;
							still_cnt_q <= '0;
						end else begin
							avg_cnt_q <= avg_next;
						end
					end
					default: begin
						avg_cnt_q <= avg_cnt_q;
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/core/imu_still_offset_calibrator.sv
// -----------------------------------------------------------------------------
// imu_still_offset_calibrator
// Six-axis IMU offset removal with stillness-gated bias calibration
// -----------------------------------------------------------------------------
// Takes one sample request per clock while sample_stall is low and returns
// its corrected result in the next cycle through an output register. A result
// held by result_stall keeps sample_stall high until it is taken, so requests
// follow back to back while results drain. The only extra stall comes at the
// end of a calibration: after the request that completes averaging,
// sample_stall is held through div_s1 and div_s2 while each axis lane divides
// its sum by AVG_SAMPLES with a registered reciprocal multiply and loads the
// new offset. There is no clearing pass after reset. Configuration writes are
// always ready and are meant to arrive only while no request is in flight.
`include "assert_macros.svh"

module imu_still_offset_calibrator
	import isoc_pkg::*;
#(
	parameter int AVG_SAMPLES = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  sample_t     sample,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] thr_q;
	logic [7:0]  samples_q;
	logic [14:0] grav_q;

	logic               acc;
	logic signed [15:0] raw_a [NUM_AXES];
	logic signed [15:0] cor_a [NUM_AXES];
	logic [NUM_ACCEL-1:0] still;
	logic               prev_ld;
	lane_ctl_t          lane_ctl;
	ctrl_st_t           st;
	logic               result_valid_q;
	result_t            result_q;
	logic               upd_seen;

	assign cfg_ready    = 1'b1;
	assign sample_stall = st.busy | (result_valid_q & result_stall);
	assign acc          = sample_valid & ~sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= RST_STILL_THRESHOLD;
			samples_q <= RST_STILL_SAMPLES;
			grav_q    <= RST_GRAVITY_REF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STILL_THRESHOLD: thr_q     <= cfg_data;
				CFG_STILL_SAMPLES:   samples_q <= cfg_data[7:0];
				CFG_GRAVITY_REF:     grav_q    <= cfg_data[14:0];
				default:             thr_q     <= thr_q;
			endcase
		end
	end

	assign raw_a[0] = sample.raw_gyro_x;
	assign raw_a[1] = sample.raw_gyro_y;
	assign raw_a[2] = sample.raw_gyro_z;
	assign raw_a[3] = sample.raw_accel_x;
	assign raw_a[4] = sample.raw_accel_y;
	assign raw_a[5] = sample.raw_accel_z;

	for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
		isoc_lane #(
			.AVG_SAMPLES(AVG_SAMPLES)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.raw    (raw_a[i]),
			.grav   ((i == AX_ACCEL_Z) ? grav_q : 15'd0),
			.ctl    (lane_ctl),
			.cor    (cor_a[i])
		);
	end

	for (genvar j = 0; j < NUM_ACCEL; j++) begin : g_still
		isoc_still u_still (
			.clk    (clk),
			.arst_n (arst_n),
			.cor    (cor_a[ACCEL_BASE + j]),
			.thr    (thr_q),
			.ld     (prev_ld),
			.still  (still[j])
		);
	end

	isoc_ctrl #(
		.AVG_SAMPLES(AVG_SAMPLES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.cmd           (sample.cmd),
		.still         (still),
		.still_samples (samples_q),
		.prev_ld       (prev_ld),
		.lane_ctl      (lane_ctl),
		.st            (st)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (acc) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			result_q.cor_gyro_x      <= cor_a[0];
			result_q.cor_gyro_y      <= cor_a[1];
			result_q.cor_gyro_z      <= cor_a[2];
			result_q.cor_accel_x     <= cor_a[3];
			result_q.cor_accel_y     <= cor_a[4];
			result_q.cor_accel_z     <= cor_a[5];
			result_q.phase           <= st.phase;
			result_q.offsets_updated <= st.updated;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign upd_seen     = result_valid & result.offsets_updated;

	`ASSERT_CLK(a_div_stall, st.busy |-> sample_stall, "request taken during offset divide")
	`ASSERT_CLK(a_fin_hold, (acc && st.fin) |=> (sample_stall && st.busy), "divide missing")
	`ASSERT_NEVER(a_upd_phase, upd_seen && (result.phase != PH_RUN), "update while calibrating")

endmodule
